>>> rtl/bls_pkg.sv
// Shared constants, codes and types of the shallow-slope line generator.
`timescale 1ns / 1ps
`default_nettype none
package bls_pkg;

    localparam int COORD_BITS   = 10;
    localparam int COLOR_BITS   = 8;
    localparam int REG_BITS     = 11;
    localparam int ADDR_BITS    = 21;
    localparam int DEC_BITS     = COORD_BITS + 4;
    localparam int CFG_IDX_BITS = 1;
    // signed row offset, wide enough for either operand plus a sign
    localparam int DIFF_BITS    = ((REG_BITS > COORD_BITS) ? REG_BITS : COORD_BITS) + 1;
    localparam int PROD_BITS    = DIFF_BITS + REG_BITS + 1;

    localparam logic [REG_BITS-1:0] ROW_WIDTH_RESET = REG_BITS'(600);
    localparam logic [REG_BITS-1:0] MAX_ROW_RESET   = REG_BITS'(600);

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_STEP = 1'b1
    } t_op;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_ROW_WIDTH = 1'b0,
        CFG_MAX_ROW   = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [REG_BITS-1:0] row_width;
        logic [REG_BITS-1:0] max_row;
    } t_cfg;

    // one result between the line stage and the address stage
    typedef struct packed {
        logic                  pix_valid;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [COLOR_BITS-1:0] color;
        logic                  done;
        logic                  rejected;
    } t_pix;

endpackage
`default_nettype wire

>>> rtl/bls_in_if.sv
// Input channel: load and step words.
`timescale 1ns / 1ps
`default_nettype none
interface bls_in_if;
    import bls_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  operation;
    logic [COORD_BITS-1:0] x_start;
    logic [COORD_BITS-1:0] y_start;
    logic [COORD_BITS-1:0] x_end;
    logic [COORD_BITS-1:0] y_end;
    logic [COLOR_BITS-1:0] color;

    modport source (output valid, operation, x_start, y_start, x_end, y_end, color,
                    input ready);
    modport sink   (input valid, operation, x_start, y_start, x_end, y_end, color,
                    output ready);
endinterface
`default_nettype wire

>>> rtl/bls_out_if.sv
// Output channel: one result word per input word.
`timescale 1ns / 1ps
`default_nettype none
interface bls_out_if;
    import bls_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  pixel_valid;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [ADDR_BITS-1:0]  pixel_address;
    logic [COLOR_BITS-1:0] pixel_color;
    logic                  line_done;
    logic                  rejected;

    modport source (output valid, pixel_valid, pixel_x, pixel_y, pixel_address,
                           pixel_color, line_done, rejected,
                    input ready);
    modport sink   (input valid, pixel_valid, pixel_x, pixel_y, pixel_address,
                          pixel_color, line_done, rejected,
                    output ready);
endinterface
`default_nettype wire

>>> rtl/bls_cfg_if.sv
// Configuration write channel.
`timescale 1ns / 1ps
`default_nettype none
interface bls_cfg_if;
    import bls_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [CFG_IDX_BITS-1:0] index;
    logic [REG_BITS-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> rtl/bls_cfg.sv
// Configuration registers: row stride and y flip row.
`timescale 1ns / 1ps
`default_nettype none
module bls_cfg (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    bls_cfg_if.sink            i_cfg,
    output bls_pkg::t_cfg      o_cfg
);
    import bls_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_ROW_WIDTH: n_cfg.row_width = i_cfg.data;
                CFG_MAX_ROW:   n_cfg.max_row   = i_cfg.data;
                default:       n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.row_width <= ROW_WIDTH_RESET;
            r_cfg.max_row   <= MAX_ROW_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule
`default_nettype wire

>>> rtl/bls_core.sv
// Line stage: endpoint setup, Bresenham stepping and the first result register.
`timescale 1ns / 1ps
`default_nettype none
module bls_core (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    bls_in_if.sink        i_in,
    input  wire logic     i_dn_ready,
    output logic          o_valid,
    output bls_pkg::t_pix o_pix
);
    import bls_pkg::*;

    localparam int CW = COORD_BITS;
    localparam logic signed [CW+1:0] Y_ONE = (CW+2)'(1);

    // control
    logic r_valid, n_valid;
    logic r_active, n_active;
    // line state
    logic [CW-1:0]              r_x, n_x;
    logic [CW-1:0]              r_y, n_y;
    logic [CW-1:0]              r_end_x, n_end_x;
    logic [CW-1:0]              r_end_y, n_end_y;
    logic signed [DEC_BITS-1:0] r_dec, n_dec;
    logic signed [DEC_BITS-1:0] r_inc_flat, n_inc_flat;
    logic signed [DEC_BITS-1:0] r_inc_diag, n_inc_diag;
    logic                       r_falling, n_falling;
    logic [COLOR_BITS-1:0]      r_color, n_color;
    t_pix                       r_pix, n_pix;

    logic                       accept;
    logic signed [CW:0]         dx, dy, ady;
    logic signed [DEC_BITS-1:0] dx_w, dy_w;
    logic                       reject;
    logic                       take_diag;
    logic [CW:0]                nx;
    logic signed [CW+1:0]       yc, ny, ye;
    logic                       done;

    assign i_in.ready = !r_valid || i_dn_ready;
    assign accept     = i_in.valid && i_in.ready;
    assign o_valid    = r_valid;
    assign o_pix      = r_pix;

    // load setup
    always_comb begin
        dx     = $signed({1'b0, i_in.x_end}) - $signed({1'b0, i_in.x_start});
        dy     = $signed({1'b0, i_in.y_end}) - $signed({1'b0, i_in.y_start});
        ady    = dy[CW] ? -dy : dy;
        reject = (dx <= 0) || (ady > dx);
        dx_w   = DEC_BITS'(dx);
        dy_w   = DEC_BITS'(dy);
    end

    // one step of the active line
    always_comb begin
        take_diag = r_falling ? (r_dec <= 0) : (r_dec >= 0);
        nx        = {1'b0, r_x} + (CW+1)'(1);
        yc        = $signed({2'b00, r_y});
        ye        = $signed({2'b00, r_end_y});
        if (!take_diag) begin
            ny = yc;
        end else if (r_falling) begin
            ny = yc - Y_ONE;
        end else begin
            ny = yc + Y_ONE;
        end
        done = (nx > {1'b0, r_end_x}) || (!r_falling && (ny > ye)) ||
               (r_falling && (ny < ye));
    end

    always_comb begin
        n_valid    = r_valid;
        n_active   = r_active;
        n_x        = r_x;
        n_y        = r_y;
        n_end_x    = r_end_x;
        n_end_y    = r_end_y;
        n_dec      = r_dec;
        n_inc_flat = r_inc_flat;
        n_inc_diag = r_inc_diag;
        n_falling  = r_falling;
        n_color    = r_color;
        n_pix      = r_pix;

        if (i_dn_ready) begin
            n_valid = 1'b0;
        end
        if (accept) begin
            n_valid = 1'b1;
            n_pix   = '0;
            unique case (t_op'(i_in.operation))
                OP_LOAD: begin
                    if (reject) begin
                        n_active       = 1'b0;
                        n_pix.rejected = 1'b1;
                    end else begin
                        n_active   = 1'b1;
                        n_x        = i_in.x_start;
                        n_y        = i_in.y_start;
                        n_end_x    = i_in.x_end;
                        n_end_y    = i_in.y_end;
                        n_falling  = dy[CW];
                        n_color    = i_in.color;
                        n_inc_flat = dy_w <<< 1;
                        n_inc_diag = dy[CW] ? (dy_w <<< 1) + (dx_w <<< 1)
                                            : (dy_w <<< 1) - (dx_w <<< 1);
                        n_dec      = dy[CW] ? (dy_w <<< 1) + dx_w
                                            : (dy_w <<< 1) - dx_w;
                    end
                end
                OP_STEP: begin
                    // idle step leaves an all-zero word
                    if (r_active) begin
                        n_pix.pix_valid = 1'b1;
                        n_pix.x         = r_x;
                        n_pix.y         = r_y;
                        n_pix.color     = r_color;
                        n_pix.done      = done;
                        n_x             = nx[CW-1:0];
                        n_y             = ny[CW-1:0];
                        n_dec           = r_dec + (take_diag ? r_inc_diag : r_inc_flat);
                        n_active        = !done;
                    end
                end
                default: n_pix = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_active <= 1'b0;
        end else begin
            r_valid  <= n_valid;
            r_active <= n_active;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x        <= n_x;
        r_y        <= n_y;
        r_end_x    <= n_end_x;
        r_end_y    <= n_end_y;
        r_dec      <= n_dec;
        r_inc_flat <= n_inc_flat;
        r_inc_diag <= n_inc_diag;
        r_falling  <= n_falling;
        r_color    <= n_color;
        r_pix      <= n_pix;
    end

    a_done_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_pix.done) |-> !r_active)
        else $error("line still active after its last pixel");

    a_reject_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_pix.rejected) |-> (!r_active && !r_pix.pix_valid))
        else $error("rejected load left a line running");

    a_blank_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_pix.pix_valid) |->
            (r_pix.x == '0 && r_pix.y == '0 && r_pix.color == '0 && !r_pix.done))
        else $error("non-pixel word carries pixel data");

endmodule
`default_nettype wire

>>> rtl/bls_addr.sv
// Address stage: (max_row - y) * row_width + x into the output register.
`timescale 1ns / 1ps
`default_nettype none
module bls_addr (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire bls_pkg::t_cfg i_cfg,
    input  wire logic          i_valid,
    input  wire bls_pkg::t_pix i_pix,
    output logic               o_ready,
    bls_out_if.source          o_out
);
    import bls_pkg::*;

    logic                        r_valid, n_valid;
    t_pix                        r_pix;
    logic [ADDR_BITS-1:0]        r_addr, n_addr;
    logic signed [DIFF_BITS-1:0] row;
    logic signed [PROD_BITS-1:0] prod;
    logic                        load;

    assign o_ready = !r_valid || o_out.ready;
    assign load    = i_valid && o_ready;

    // row offset goes negative when y exceeds max_row; the low bits wrap correctly
    always_comb begin
        row    = $signed(DIFF_BITS'(i_cfg.max_row)) - $signed(DIFF_BITS'(i_pix.y));
        prod   = row * $signed({1'b0, i_cfg.row_width});
        n_addr = i_pix.pix_valid ? prod[ADDR_BITS-1:0] + ADDR_BITS'(i_pix.x) : '0;
    end

    always_comb begin
        n_valid = r_valid;
        if (o_out.ready) begin
            n_valid = 1'b0;
        end
        if (load) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_pix  <= i_pix;
            r_addr <= n_addr;
        end
    end

    assign o_out.valid         = r_valid;
    assign o_out.pixel_valid   = r_pix.pix_valid;
    assign o_out.pixel_x       = r_pix.x;
    assign o_out.pixel_y       = r_pix.y;
    assign o_out.pixel_address = r_addr;
    assign o_out.pixel_color   = r_pix.color;
    assign o_out.line_done     = r_pix.done;
    assign o_out.rejected      = r_pix.rejected;

    a_blank_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_pix.pix_valid) |-> (r_addr == '0))
        else $error("non-pixel word carries an address");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !o_out.ready) |=> (r_valid && $stable(r_addr)))
        else $error("stalled result word changed");

endmodule
`default_nettype wire

>>> rtl/bresenham_line_shallow_unit.sv
// Top level of the shallow-slope Bresenham line generator.
//
//  channel  dir  handshake       word
//  i_in     in   valid / ready   operation, endpoints, color
//  o_out    out  valid / ready   pixel flags, x, y, address, color
//  i_cfg    in   valid / ready   register index, data (ready always high)
//
// One word in, one word out; a new word is taken every cycle when o_out drains.
// The line stage steps the error term and registers its word, then the address
// stage does the one 12x12 multiply-add and registers the result.
// Stalls on o_out back up through both stages to i_in.ready.
// Synchronous active-low reset idles the line and restores row_width/max_row to 600.
`timescale 1ns / 1ps
`default_nettype none
module bresenham_line_shallow_unit (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    bls_in_if.sink    i_in,
    bls_out_if.source o_out,
    bls_cfg_if.sink   i_cfg
);
    import bls_pkg::*;

    t_cfg cfg;
    t_pix line_pix;
    logic line_valid;
    logic addr_ready;

    bls_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    bls_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_dn_ready (addr_ready),
        .o_valid    (line_valid),
        .o_pix      (line_pix)
    );

    bls_addr u_addr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (line_valid),
        .i_pix   (line_pix),
        .o_ready (addr_ready),
        .o_out   (o_out)
    );

endmodule
`default_nettype wire

>>> tb/bresenham_line_shallow_unit_tb.sv
// Self-checking testbench for the shallow-slope Bresenham line unit: loads, steps, rejects.
`timescale 1ns / 1ps
module bresenham_line_shallow_unit_tb;
    import bls_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 400;
    localparam int SHOW_ERRORS = 10;

    typedef struct {
        t_op                   op;
        logic [COORD_BITS-1:0] xs;
        logic [COORD_BITS-1:0] ys;
        logic [COORD_BITS-1:0] xe;
        logic [COORD_BITS-1:0] ye;
        logic [COLOR_BITS-1:0] color;
    } t_line_word;

    typedef struct packed {
        logic                  pixel_valid;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [ADDR_BITS-1:0]  address;
        logic [COLOR_BITS-1:0] color;
        logic                  done;
        logic                  rejected;
    } t_pixel_word;

    logic i_clk;
    logic i_rst_n;

    bls_in_if  in_bus ();
    bls_out_if out_bus ();
    bls_cfg_if cfg_bus ();

    bresenham_line_shallow_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .i_cfg   (cfg_bus)
    );

    t_line_word  word_q[$];
    t_pixel_word pixel_expect_q[$];
    t_line_word  offered_word;

    int tx_idle_pct = 26;
    int rx_idle_pct = 83;
    bit hold_req    = 1'b0;
    logic hold_active = 1'b0;
    int err_cnt     = 0;
    int cycle_cnt   = 0;
    int words_taken = 0;

    // coverage tallies
    int n_lines      = 0;
    int n_refused    = 0;
    int n_pixels     = 0;
    int n_ends       = 0;
    int n_idle_steps = 0;
    int n_settings   = 1;

    // predicted line state and register shadows
    logic [REG_BITS-1:0]   stride_reg   = ROW_WIDTH_RESET;
    logic [REG_BITS-1:0]   flip_row_reg = MAX_ROW_RESET;
    int                    ln_x = 0, ln_y = 0, ln_end_x = 0, ln_end_y = 0;
    int                    ln_dx = 0, ln_dy = 0, ln_err = 0;
    bit                    ln_falling = 1'b0;
    bit                    ln_active  = 1'b0;
    logic [COLOR_BITS-1:0] ln_color   = '0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic t_pixel_word trace_line(t_line_word w);
        t_pixel_word r;
        int          dx, dy;
        logic [31:0] row, addr;
        r = '0;
        if (w.op == OP_LOAD) begin
            dx = int'(w.xe) - int'(w.xs);
            dy = int'(w.ye) - int'(w.ys);
            if (dx <= 0 || (dy < 0 ? -dy : dy) > dx) begin
                ln_active  = 1'b0;
                r.rejected = 1'b1;
                n_refused++;
            end else begin
                ln_x       = int'(w.xs);
                ln_y       = int'(w.ys);
                ln_end_x   = int'(w.xe);
                ln_end_y   = int'(w.ye);
                ln_dx      = dx;
                ln_dy      = dy;
                ln_falling = (dy < 0);
                ln_err     = ln_falling ? 2 * dy + dx : 2 * dy - dx;
                ln_color   = w.color;
                ln_active  = 1'b1;
                n_lines++;
            end
        end else if (!ln_active) begin
            n_idle_steps++;
        end else begin
            // y above the flip row wraps the address mod 2^21
            row  = (32'(flip_row_reg) - 32'(ln_y)) & 32'h1F_FFFF;
            addr = (row * 32'(stride_reg) + 32'(ln_x)) & 32'h1F_FFFF;
            r.pixel_valid = 1'b1;
            r.x           = COORD_BITS'(ln_x);
            r.y           = COORD_BITS'(ln_y);
            r.address     = ADDR_BITS'(addr);
            r.color       = ln_color;
            if (!ln_falling) begin
                if (ln_err >= 0) begin
                    ln_err += 2 * ln_dy - 2 * ln_dx;
                    ln_y++;
                end else begin
                    ln_err += 2 * ln_dy;
                end
            end else begin
                if (ln_err <= 0) begin
                    ln_err += 2 * ln_dy + 2 * ln_dx;
                    ln_y--;
                end else begin
                    ln_err += 2 * ln_dy;
                end
            end
            ln_x++;
            if (ln_x > ln_end_x || (!ln_falling && ln_y > ln_end_y) ||
                (ln_falling && ln_y < ln_end_y)) begin
                ln_active = 1'b0;
                r.done    = 1'b1;
                n_ends++;
            end
            n_pixels++;
        end
        return r;
    endfunction

    function automatic t_line_word load_word(int xs, int ys, int xe, int ye, int color);
        t_line_word w;
        w.op    = OP_LOAD;
        w.xs    = COORD_BITS'(xs);
        w.ys    = COORD_BITS'(ys);
        w.xe    = COORD_BITS'(xe);
        w.ye    = COORD_BITS'(ye);
        w.color = COLOR_BITS'(color);
        return w;
    endfunction

    // step words carry junk in the unused fields when junk is set
    task automatic push_steps(int count, bit junk);
        t_line_word w;
        repeat (count) begin
            w = load_word(0, 0, 0, 0, 0);
            w.op = OP_STEP;
            if (junk) begin
                w.xs    = COORD_BITS'($urandom);
                w.ys    = COORD_BITS'($urandom);
                w.xe    = COORD_BITS'($urandom);
                w.ye    = COORD_BITS'($urandom);
                w.color = COLOR_BITS'($urandom);
            end
            word_q.push_back(w);
        end
    endtask

    task automatic queue_random_words(int n_words);
        int made, pick, sel, dx, dy, xs, ys, k, steps;
        t_line_word w;
        made = 0;
        while (made < n_words) begin
            pick = $urandom_range(99);
            if (pick < 72) begin
                sel = $urandom_range(99);
                dx  = (sel < 80) ? $urandom_range(15, 1) :
                      (sel < 97) ? $urandom_range(120, 16) : $urandom_range(1023, 121);
                dy  = int'($urandom_range(2 * dx)) - dx;
                xs  = $urandom_range(1023 - dx);
                ys  = (dy >= 0) ? $urandom_range(1023 - dy) : $urandom_range(1023, -dy);
                word_q.push_back(load_word(xs, ys, xs + dx, ys + dy, $urandom_range(255)));
                steps = dx + 1;
                sel   = $urandom_range(9);
                if (sel == 0)
                    steps = $urandom_range(dx);         // cut short, next load replaces it
                else if (sel == 1)
                    steps += $urandom_range(3, 1);      // run past the end
                push_steps(steps, 1'b1);
                made += steps + 1;
            end else if (pick < 85) begin
                xs = $urandom_range(1023);
                ys = $urandom_range(1023);
                if ($urandom_range(1)) begin
                    // backwards or zero-length
                    word_q.push_back(load_word(xs, ys, $urandom_range(xs), $urandom_range(1023),
                                               $urandom_range(255)));
                end else begin
                    // too steep
                    xs = $urandom_range(1000);
                    dx = $urandom_range(20, 1);
                    k  = dx + 1 + $urandom_range(10);
                    dy = (ys + k <= 1023 && ($urandom_range(1) || ys < k)) ? k : -k;
                    word_q.push_back(load_word(xs, ys, xs + dx, ys + dy, $urandom_range(255)));
                end
                if ($urandom_range(1))
                    push_steps(1, 1'b1);
                made += 2;
            end else begin
                w = load_word($urandom, $urandom, $urandom, $urandom, $urandom);
                w.op = $urandom_range(1) ? OP_STEP : OP_LOAD;
                word_q.push_back(w);
                made++;
            end
        end
    endtask

    // checked on the falling edge so the driver's updates at the rising edge have landed
    task automatic settle();
        while (word_q.size() != 0 || in_bus.valid || pixel_expect_q.size() != 0)
            @(negedge i_clk);
        // two-stage pipe, leave it some slack
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [REG_BITS-1:0] val);
        @(posedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        do @(posedge i_clk); while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        case (idx)
            CFG_ROW_WIDTH: stride_reg   = val;
            CFG_MAX_ROW:   flip_row_reg = val;
            default: ;
        endcase
    endtask

    task automatic run_phase(int stride, int flip, int tx_pct, int rx_pct, int n_words);
        settle();
        write_reg(CFG_ROW_WIDTH, REG_BITS'(stride));
        write_reg(CFG_MAX_ROW, REG_BITS'(flip));
        n_settings++;
        tx_idle_pct <= tx_pct;
        rx_idle_pct <= rx_pct;
        queue_random_words(n_words);
    endtask

    task automatic note_error(bit orphan, t_pixel_word exp, t_pixel_word got);
        err_cnt++;
        if (err_cnt <= SHOW_ERRORS) begin
            if (orphan) begin
                $write("ERROR: result with nothing pending: ");
                $display("pv=%0b x=%0d y=%0d adr=%0d c=%0d d=%0b r=%0b",
                         got.pixel_valid, got.x, got.y, got.address, got.color, got.done,
                         got.rejected);
            end else begin
                $write("ERROR: exp pv=%0b x=%0d y=%0d adr=%0d c=%0d d=%0b r=%0b",
                       exp.pixel_valid, exp.x, exp.y, exp.address, exp.color, exp.done,
                       exp.rejected);
                $display(" | got pv=%0b x=%0d y=%0d adr=%0d c=%0d d=%0b r=%0b",
                         got.pixel_valid, got.x, got.y, got.address, got.color,
                         got.done, got.rejected);
            end
        end
    endtask

    // input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_bus.valid <= 1'b0;
        end else begin
            if (in_bus.valid && in_bus.ready) begin
                pixel_expect_q.push_back(trace_line(offered_word));
                words_taken++;
            end
            if (!in_bus.valid || in_bus.ready) begin
                if (word_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    offered_word     = word_q.pop_front();
                    in_bus.operation <= offered_word.op;
                    in_bus.x_start   <= offered_word.xs;
                    in_bus.y_start   <= offered_word.ys;
                    in_bus.x_end     <= offered_word.xe;
                    in_bus.y_end     <= offered_word.ye;
                    in_bus.color     <= offered_word.color;
                    in_bus.valid     <= 1'b1;
                end else begin
                    in_bus.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n)
            out_bus.ready <= 1'b0;
        else
            out_bus.ready <= !hold_active && ($urandom_range(99) >= rx_idle_pct);
    end

    // long receiver hold-off so the pipe fills and backs up into the input
    initial begin
        wait (hold_req);
        @(posedge i_clk);
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_active <= 1'b0;
    end

    // result monitor
    always @(posedge i_clk) begin
        t_pixel_word got;
        t_pixel_word exp;
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            got.pixel_valid = out_bus.pixel_valid;
            got.x           = out_bus.pixel_x;
            got.y           = out_bus.pixel_y;
            got.address     = out_bus.pixel_address;
            got.color       = out_bus.pixel_color;
            got.done        = out_bus.line_done;
            got.rejected    = out_bus.rejected;
            if (pixel_expect_q.size() == 0) begin
                note_error(1'b1, '0, got);
            end else begin
                exp = pixel_expect_q.pop_front();
                if (got !== exp)
                    note_error(1'b0, exp, got);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, pixel_expect_q.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        i_rst_n          = 1'b0;
        in_bus.valid     = 1'b0;
        in_bus.operation = OP_LOAD;
        in_bus.x_start   = '0;
        in_bus.y_start   = '0;
        in_bus.x_end     = '0;
        in_bus.y_end     = '0;
        in_bus.color     = '0;
        out_bus.ready    = 1'b0;
        cfg_bus.valid    = 1'b0;
        cfg_bus.index    = CFG_ROW_WIDTH;
        cfg_bus.data     = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: idle step, full-span lines, every reject kind, replace, x past 1023
        push_steps(1, 1'b0);
        word_q.push_back(load_word(0, 0, 1023, 1023, 255));
        push_steps(3, 1'b0);
        word_q.push_back(load_word(5, 5, 5, 5, 17));            // zero extent drops the line
        push_steps(1, 1'b0);
        word_q.push_back(load_word(1023, 0, 0, 0, 255));        // backwards
        word_q.push_back(load_word(0, 0, 1, 2, 255));           // steeper than 45 deg
        word_q.push_back(load_word(0, 1023, 1023, 0, 0));
        push_steps(2, 1'b0);
        word_q.push_back(load_word(10, 20, 12, 19, 8'hA5));     // replaces the active line
        push_steps(4, 1'b0);
        word_q.push_back(load_word(1020, 500, 1023, 500, 8'h3C));
        push_steps(4, 1'b0);
        word_q.push_back(load_word(0, 3, 3, 0, 8'h5A));
        push_steps(2, 1'b0);
        queue_random_words(250);

        run_phase(1024, 1024, 26, 83, 300);
        hold_req = 1'b1;
        run_phase(1, 0, 83, 26, 300);                            // most rows above the flip
        run_phase(0, 1023, 83, 26, 300);                         // zero stride
        run_phase($urandom_range(1024, 1), $urandom_range(1024), 0, 0, 300);
        run_phase(640, 479, 0, 0, 300);

        settle();
        repeat (8) @(posedge i_clk);
        err_cnt += pixel_expect_q.size();

        $display("Ran %0d words over %0d register settings: %0d lines, %0d refused loads,",
                 words_taken, n_settings, n_lines, n_refused);
        $display("%0d pixels, %0d line ends, %0d idle steps, %0d errors",
                 n_pixels, n_ends, n_idle_steps, err_cnt);
        if (err_cnt == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
